/* rtl/asc_pkg.sv */
// asc_pkg: shared types, constants and the permutation round of the ascon engine
// used by every module under rtl; no dependencies

package asc_pkg;

    localparam int LANE_W = 64;
    localparam int NUM_LANES = 5;
    localparam int RC_W = 4;
    localparam int CFG_IDX_W = 1;

    localparam int OPQ_DEPTH = 2;
    localparam int OUTQ_DEPTH = 2;

    localparam logic [LANE_W-1:0] ASCON_IV = 64'h80400c0600000000;
    localparam logic [LANE_W-1:0] DOMAIN_SEP = 64'h0000000000000001;
    localparam logic [RC_W-1:0] RC_FULL_FIRST = 4'd0;
    localparam logic [RC_W-1:0] RC_HALF_FIRST = 4'd6;
    localparam logic [RC_W-1:0] RC_LAST = 4'd11;

    localparam logic [CFG_IDX_W-1:0] REG_KEY0 = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_KEY1 = 1'd1;

    typedef enum logic [2:0] {
        CMD_START = 3'd0,
        CMD_ABSORB = 3'd1,
        CMD_CLOSE_AD = 3'd2,
        CMD_ENCRYPT = 3'd3,
        CMD_DECRYPT = 3'd4,
        CMD_FINALIZE = 3'd5
    } t_cmd;

    localparam logic RESULT_TEXT = 1'b0;
    localparam logic RESULT_TAG = 1'b1;

    typedef logic [NUM_LANES-1:0][LANE_W-1:0] t_lanes;

    typedef struct packed {
        logic [2:0] cmd;
        logic [LANE_W-1:0] data_in;
        logic [LANE_W-1:0] nonce_second;
        logic is_last;
    } t_in_item;

    typedef struct packed {
        logic [LANE_W-1:0] word_out;
        logic [LANE_W-1:0] tag_second;
        logic result_kind;
    } t_out_item;

    typedef struct packed {
        t_cmd cmd;
        logic [LANE_W-1:0] data;
        logic [LANE_W-1:0] nonce;
        logic no_perm;
    } t_op;

    typedef struct packed {
        logic valid;
        logic full;
    } t_q_status;

    function automatic logic [LANE_W-1:0] asc_rotr(input logic [LANE_W-1:0] x, input int n);
        asc_rotr = (x >> n) | (x << (LANE_W - n));
    endfunction

    function automatic t_lanes asc_round(input t_lanes s, input logic [RC_W-1:0] rc);
        logic [LANE_W-1:0] x0, x1, x2, x3, x4;
        logic [LANE_W-1:0] t0, t1, t2, t3, t4;
        t_lanes r;
        x0 = s[0];
        x1 = s[1];
        x2 = s[2] ^ {{(LANE_W-2*RC_W){1'b0}}, ~rc, rc};
        x3 = s[3];
        x4 = s[4];
        x0 = x0 ^ x4;
        x4 = x4 ^ x3;
        x2 = x2 ^ x1;
        t0 = ~x0 & x1;
        t1 = ~x1 & x2;
        t2 = ~x2 & x3;
        t3 = ~x3 & x4;
        t4 = ~x4 & x0;
        x0 = x0 ^ t1;
        x1 = x1 ^ t2;
        x2 = x2 ^ t3;
        x3 = x3 ^ t4;
        x4 = x4 ^ t0;
        x1 = x1 ^ x0;
        x0 = x0 ^ x4;
        x3 = x3 ^ x2;
        x2 = ~x2;
        r[0] = x0 ^ asc_rotr(x0, 19) ^ asc_rotr(x0, 28);
        r[1] = x1 ^ asc_rotr(x1, 61) ^ asc_rotr(x1, 39);
        r[2] = x2 ^ asc_rotr(x2, 1) ^ asc_rotr(x2, 6);
        r[3] = x3 ^ asc_rotr(x3, 10) ^ asc_rotr(x3, 17);
        r[4] = x4 ^ asc_rotr(x4, 7) ^ asc_rotr(x4, 41);
        asc_round = r;
    endfunction

endpackage

/* rtl/asc_front.sv */
// asc_front: accepts input requests, decodes the command and queues operations
// depends on asc_pkg

module asc_front (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                push,
    output logic                full,
    input  asc_pkg::t_in_item   i_req,
    output asc_pkg::t_q_status  o_status,
    output asc_pkg::t_op        o_op,
    input  logic                i_op_pop
);

    localparam int Depth = asc_pkg::OPQ_DEPTH;
    localparam int PtrW = $clog2(Depth);
    localparam int CntW = $clog2(Depth + 1);

    asc_pkg::t_op r_mem [Depth];
    logic [PtrW-1:0] r_wr, r_rd, n_wr, n_rd;
    logic [CntW-1:0] r_cnt, n_cnt;
    logic w_cmd_ok, w_enq, w_deq;
    asc_pkg::t_op w_op;

    assign full = (r_cnt == CntW'(Depth));
    assign w_cmd_ok = (i_req.cmd == asc_pkg::CMD_START) || (i_req.cmd == asc_pkg::CMD_ABSORB)
        || (i_req.cmd == asc_pkg::CMD_CLOSE_AD) || (i_req.cmd == asc_pkg::CMD_ENCRYPT)
        || (i_req.cmd == asc_pkg::CMD_DECRYPT) || (i_req.cmd == asc_pkg::CMD_FINALIZE);
    assign w_enq = push && !full && w_cmd_ok;
    assign w_deq = i_op_pop && (r_cnt != '0);

    always_comb begin
        w_op.cmd = asc_pkg::t_cmd'(i_req.cmd);
        w_op.data = i_req.data_in;
        w_op.nonce = i_req.nonce_second;
        w_op.no_perm = i_req.is_last && ((i_req.cmd == asc_pkg::CMD_ENCRYPT)
            || (i_req.cmd == asc_pkg::CMD_DECRYPT));
    end

    always_comb begin
        n_wr = r_wr;
        n_rd = r_rd;
        n_cnt = r_cnt;
        if (w_enq) begin
            n_wr = (r_wr == PtrW'(Depth - 1)) ? '0 : r_wr + 1'b1;
        end
        if (w_deq) begin
            n_rd = (r_rd == PtrW'(Depth - 1)) ? '0 : r_rd + 1'b1;
        end
        if (w_enq && !w_deq) begin
            n_cnt = r_cnt + 1'b1;
        end else if (!w_enq && w_deq) begin
            n_cnt = r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr <= '0;
            r_rd <= '0;
            r_cnt <= '0;
        end else begin
            r_wr <= n_wr;
            r_rd <= n_rd;
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_enq) begin
            r_mem[r_wr] <= w_op;
        end
    end

    assign o_status.valid = (r_cnt != '0);
    assign o_status.full = full;
    assign o_op = r_mem[r_rd];

endmodule

/* rtl/asc_back.sv */
// asc_back: lane state and round sequencer, one permutation round per cycle
// depends on asc_pkg

module asc_back (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic [asc_pkg::LANE_W-1:0] i_key0,
    input  logic [asc_pkg::LANE_W-1:0] i_key1,
    input  asc_pkg::t_q_status         i_op_status,
    input  asc_pkg::t_op               i_op,
    output logic                       o_op_pop,
    input  logic                       i_res_full,
    output logic                       o_res_push,
    output asc_pkg::t_out_item         o_res
);

    typedef enum logic {
        ST_IDLE,
        ST_RUN
    } t_state_e;

    t_state_e r_state, n_state;
    asc_pkg::t_lanes r_lanes, n_lanes, w_rnd;
    logic [asc_pkg::RC_W-1:0] r_rc, n_rc;
    logic r_fin_key, n_fin_key;
    logic r_tag, n_tag;

    assign w_rnd = asc_pkg::asc_round(r_lanes, r_rc);

    always_comb begin
        n_state = r_state;
        n_lanes = r_lanes;
        n_rc = r_rc;
        n_fin_key = r_fin_key;
        n_tag = r_tag;
        o_op_pop = 1'b0;
        o_res_push = 1'b0;
        o_res = '0;
        case (r_state)
            ST_IDLE: begin
                if (i_op_status.valid && !i_res_full) begin
                    o_op_pop = 1'b1;
                    n_rc = asc_pkg::RC_HALF_FIRST;
                    n_fin_key = 1'b0;
                    n_tag = 1'b0;
                    case (i_op.cmd)
                        asc_pkg::CMD_START: begin
                            n_lanes[0] = asc_pkg::ASCON_IV;
                            n_lanes[1] = i_key0;
                            n_lanes[2] = i_key1;
                            n_lanes[3] = i_op.data;
                            n_lanes[4] = i_op.nonce;
                            n_rc = asc_pkg::RC_FULL_FIRST;
                            n_fin_key = 1'b1;
                            n_state = ST_RUN;
                        end
                        asc_pkg::CMD_ABSORB: begin
                            n_lanes[0] = r_lanes[0] ^ i_op.data;
                            n_state = ST_RUN;
                        end
                        asc_pkg::CMD_CLOSE_AD: begin
                            n_lanes[4] = r_lanes[4] ^ asc_pkg::DOMAIN_SEP;
                        end
                        asc_pkg::CMD_ENCRYPT: begin
                            n_lanes[0] = r_lanes[0] ^ i_op.data;
                            o_res_push = 1'b1;
                            o_res.word_out = r_lanes[0] ^ i_op.data;
                            o_res.result_kind = asc_pkg::RESULT_TEXT;
                            n_state = i_op.no_perm ? ST_IDLE : ST_RUN;
                        end
                        asc_pkg::CMD_DECRYPT: begin
                            n_lanes[0] = i_op.data;
                            o_res_push = 1'b1;
                            o_res.word_out = r_lanes[0] ^ i_op.data;
                            o_res.result_kind = asc_pkg::RESULT_TEXT;
                            n_state = i_op.no_perm ? ST_IDLE : ST_RUN;
                        end
                        asc_pkg::CMD_FINALIZE: begin
                            n_lanes[1] = r_lanes[1] ^ i_key0;
                            n_lanes[2] = r_lanes[2] ^ i_key1;
                            n_rc = asc_pkg::RC_FULL_FIRST;
                            n_fin_key = 1'b1;
                            n_tag = 1'b1;
                            n_state = ST_RUN;
                        end
                        default: begin
                            n_state = ST_IDLE;
                        end
                    endcase
                end
            end
            ST_RUN: begin
                n_lanes = w_rnd;
                n_rc = r_rc + 1'b1;
                if (r_rc == asc_pkg::RC_LAST) begin
                    n_state = ST_IDLE;
                    if (r_fin_key) begin
                        n_lanes[3] = w_rnd[3] ^ i_key0;
                        n_lanes[4] = w_rnd[4] ^ i_key1;
                    end
                    if (r_tag) begin
                        o_res_push = 1'b1;
                        o_res.word_out = w_rnd[3] ^ i_key0;
                        o_res.tag_second = w_rnd[4] ^ i_key1;
                        o_res.result_kind = asc_pkg::RESULT_TAG;
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_lanes <= '0;
            r_rc <= '0;
            r_fin_key <= 1'b0;
            r_tag <= 1'b0;
        end else begin
            r_state <= n_state;
            r_lanes <= n_lanes;
            r_rc <= n_rc;
            r_fin_key <= n_fin_key;
            r_tag <= n_tag;
        end
    end

endmodule

/* rtl/asc_outq.sv */
// asc_outq: result queue between the round sequencer and the result port
// depends on asc_pkg

module asc_outq (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_push,
    input  asc_pkg::t_out_item i_item,
    output logic               o_full,
    output logic               empty,
    input  logic               pop,
    output asc_pkg::t_out_item o_rsp
);

    localparam int Depth = asc_pkg::OUTQ_DEPTH;
    localparam int PtrW = $clog2(Depth);
    localparam int CntW = $clog2(Depth + 1);

    asc_pkg::t_out_item r_mem [Depth];
    logic [PtrW-1:0] r_wr, r_rd, n_wr, n_rd;
    logic [CntW-1:0] r_cnt, n_cnt;
    logic w_enq, w_deq;

    assign o_full = (r_cnt == CntW'(Depth));
    assign empty = (r_cnt == '0);
    assign w_enq = i_push && !o_full;
    assign w_deq = pop && !empty;

    always_comb begin
        n_wr = r_wr;
        n_rd = r_rd;
        n_cnt = r_cnt;
        if (w_enq) begin
            n_wr = (r_wr == PtrW'(Depth - 1)) ? '0 : r_wr + 1'b1;
        end
        if (w_deq) begin
            n_rd = (r_rd == PtrW'(Depth - 1)) ? '0 : r_rd + 1'b1;
        end
        if (w_enq && !w_deq) begin
            n_cnt = r_cnt + 1'b1;
        end else if (!w_enq && w_deq) begin
            n_cnt = r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr <= '0;
            r_rd <= '0;
            r_cnt <= '0;
        end else begin
            r_wr <= n_wr;
            r_rd <= n_rd;
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_enq) begin
            r_mem[r_wr] <= i_item;
        end
    end

    assign o_rsp = r_mem[r_rd];

endmodule

/* rtl/ascon_aead_engine.sv */
// ascon_aead_engine: requests pass the operation queue, results the result queue, both registered
// the round sequencer takes no new operation until its rounds are done, one round per cycle:
// half rounds per ad or text block, full for start or finalize, none for close-ad or last text
// reset is synchronous, active low; clears lanes, key registers and both queues
// depends on asc_pkg, asc_front, asc_back, asc_outq

module ascon_aead_engine (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          push,
    output logic                          full,
    input  asc_pkg::t_in_item             i_req,
    output logic                          empty,
    input  logic                          pop,
    output asc_pkg::t_out_item            o_rsp,
    input  logic                          i_cfg_we,
    input  logic [asc_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [asc_pkg::LANE_W-1:0]    i_cfg_data
);

    logic [asc_pkg::LANE_W-1:0] r_key0, r_key1;
    asc_pkg::t_q_status w_op_status;
    asc_pkg::t_op w_op;
    logic w_op_pop;
    logic w_res_full, w_res_push;
    asc_pkg::t_out_item w_res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key0 <= '0;
            r_key1 <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                asc_pkg::REG_KEY0: r_key0 <= i_cfg_data;
                asc_pkg::REG_KEY1: r_key1 <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    asc_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .push     (push),
        .full     (full),
        .i_req    (i_req),
        .o_status (w_op_status),
        .o_op     (w_op),
        .i_op_pop (w_op_pop)
    );

    asc_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_key0      (r_key0),
        .i_key1      (r_key1),
        .i_op_status (w_op_status),
        .i_op        (w_op),
        .o_op_pop    (w_op_pop),
        .i_res_full  (w_res_full),
        .o_res_push  (w_res_push),
        .o_res       (w_res)
    );

    asc_outq u_outq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_res_push),
        .i_item  (w_res),
        .o_full  (w_res_full),
        .empty   (empty),
        .pop     (pop),
        .o_rsp   (o_rsp)
    );

`ifndef SYNTHESIS
    a_no_res_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_res_push |-> !w_res_full)
        else $error("result pushed into full queue");

    a_pop_needs_op: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_op_pop |-> w_op_status.valid)
        else $error("operation taken from empty queue");

    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> (empty && !full))
        else $error("queues not cleared by reset");
`endif

endmodule

/* verif/ascon_aead_engine_checker.sv */
// ascon_aead_engine_checker: watches request, response and key-write traffic of the engine,
// keeps its own copy of the lane state and keys, and compares every response in order
// depends on asc_pkg for the port payload types and command names

module ascon_aead_engine_checker (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_push,
    input  logic                          i_full,
    input  asc_pkg::t_in_item             i_req,
    input  logic                          i_empty,
    input  logic                          i_pop,
    input  asc_pkg::t_out_item            i_rsp,
    input  logic                          i_cfg_we,
    input  logic [asc_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [asc_pkg::LANE_W-1:0]    i_cfg_data,
    output int                            o_fail_cnt,
    output int                            o_pending,
    output int                            o_req_cnt,
    output int                            o_text_cnt,
    output int                            o_tag_cnt
);
    timeunit 1ns;
    timeprecision 1ps;

    import asc_pkg::*;

    localparam logic [LANE_W-1:0] IV_WORD = 64'h80400c0600000000;
    localparam logic [LANE_W-1:0] DOMAIN_BIT = 64'h0000000000000001;
    localparam int unsigned FULL_ROUNDS = 12;
    localparam int unsigned HALF_ROUNDS = 6;
    localparam int MAX_PRINTED = 40;

    t_lanes            lanes_st;
    logic [LANE_W-1:0] key_w0;
    logic [LANE_W-1:0] key_w1;
    t_out_item         expected_rsp_q[$];
    int                fail_cnt = 0;
    int                req_cnt = 0;
    int                text_cnt = 0;
    int                tag_cnt = 0;

    function automatic logic [LANE_W-1:0] rot_right(input logic [LANE_W-1:0] v,
                                                    input int unsigned n);
        logic [2*LANE_W-1:0] w;
        w = {v, v} >> n;
        return w[LANE_W-1:0];
    endfunction

    function automatic t_lanes ascon_round(input t_lanes s, input int unsigned r);
        logic [LANE_W-1:0] a0, a1, a2, a3, a4;
        logic [LANE_W-1:0] b0, b1, b2, b3, b4;
        logic [3:0]        ri;
        t_lanes            nxt;
        ri = 4'(r);
        a0 = s[0];
        a1 = s[1];
        a2 = s[2] ^ {56'd0, 4'hf - ri, ri};
        a3 = s[3];
        a4 = s[4];
        // s-box layer
        a0 ^= a4;
        a4 ^= a3;
        a2 ^= a1;
        b0 = ~a0 & a1;
        b1 = ~a1 & a2;
        b2 = ~a2 & a3;
        b3 = ~a3 & a4;
        b4 = ~a4 & a0;
        a0 ^= b1;
        a1 ^= b2;
        a2 ^= b3;
        a3 ^= b4;
        a4 ^= b0;
        a1 ^= a0;
        a0 ^= a4;
        a3 ^= a2;
        a2 = ~a2;
        // linear diffusion layer
        nxt[0] = a0 ^ rot_right(a0, 19) ^ rot_right(a0, 28);
        nxt[1] = a1 ^ rot_right(a1, 61) ^ rot_right(a1, 39);
        nxt[2] = a2 ^ rot_right(a2, 1) ^ rot_right(a2, 6);
        nxt[3] = a3 ^ rot_right(a3, 10) ^ rot_right(a3, 17);
        nxt[4] = a4 ^ rot_right(a4, 7) ^ rot_right(a4, 41);
        return nxt;
    endfunction

    function automatic t_lanes ascon_permute(input t_lanes s, input int unsigned nr);
        t_lanes v;
        v = s;
        for (int unsigned i = 0; i < nr; i++) begin
            v = ascon_round(v, FULL_ROUNDS - nr + i);
        end
        return v;
    endfunction

    task automatic predict_request(input t_in_item rq);
        t_out_item res;
        logic      has_res;
        res = '0;
        has_res = 1'b0;
        req_cnt++;
        case (rq.cmd)
            CMD_START: begin
                lanes_st[0] = IV_WORD;
                lanes_st[1] = key_w0;
                lanes_st[2] = key_w1;
                lanes_st[3] = rq.data_in;
                lanes_st[4] = rq.nonce_second;
                lanes_st = ascon_permute(lanes_st, FULL_ROUNDS);
                lanes_st[3] ^= key_w0;
                lanes_st[4] ^= key_w1;
            end
            CMD_ABSORB: begin
                lanes_st[0] ^= rq.data_in;
                lanes_st = ascon_permute(lanes_st, HALF_ROUNDS);
            end
            CMD_CLOSE_AD: begin
                lanes_st[4] ^= DOMAIN_BIT;
            end
            CMD_ENCRYPT: begin
                lanes_st[0] ^= rq.data_in;
                res.word_out = lanes_st[0];
                res.result_kind = RESULT_TEXT;
                has_res = 1'b1;
                if (!rq.is_last) lanes_st = ascon_permute(lanes_st, HALF_ROUNDS);
            end
            CMD_DECRYPT: begin
                res.word_out = rq.data_in ^ lanes_st[0];
                res.result_kind = RESULT_TEXT;
                has_res = 1'b1;
                lanes_st[0] = rq.data_in;
                if (!rq.is_last) lanes_st = ascon_permute(lanes_st, HALF_ROUNDS);
            end
            CMD_FINALIZE: begin
                lanes_st[1] ^= key_w0;
                lanes_st[2] ^= key_w1;
                lanes_st = ascon_permute(lanes_st, FULL_ROUNDS);
                lanes_st[3] ^= key_w0;
                lanes_st[4] ^= key_w1;
                res.word_out = lanes_st[3];
                res.tag_second = lanes_st[4];
                res.result_kind = RESULT_TAG;
                has_res = 1'b1;
            end
            default: ;
        endcase
        if (has_res) expected_rsp_q.push_back(res);
    endtask

    task automatic report_mismatch(input string what, input logic [LANE_W-1:0] got,
                                   input logic [LANE_W-1:0] want);
        fail_cnt++;
        if (fail_cnt <= MAX_PRINTED) begin
            $display("%0t ns: mismatch on %s: got %h expected %h", $time, what, got, want);
        end
    endtask

    task automatic check_response(input t_out_item got);
        t_out_item want;
        if (expected_rsp_q.size() == 0) begin
            report_mismatch("response with nothing pending", got.word_out, '0);
        end else begin
            want = expected_rsp_q.pop_front();
            if (want.result_kind == RESULT_TAG) tag_cnt++;
            else text_cnt++;
            if (got.word_out !== want.word_out) begin
                report_mismatch("word_out", got.word_out, want.word_out);
            end
            if (got.tag_second !== want.tag_second) begin
                report_mismatch("tag_second", got.tag_second, want.tag_second);
            end
            if (got.result_kind !== want.result_kind) begin
                report_mismatch("result_kind", LANE_W'(got.result_kind),
                                LANE_W'(want.result_kind));
            end
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            lanes_st = '0;
            key_w0 = '0;
            key_w1 = '0;
            expected_rsp_q.delete();
        end else begin
            // a response cannot stem from a request taken at the same edge
            if (i_pop && !i_empty) check_response(i_rsp);
            if (i_push && !i_full) predict_request(i_req);
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    REG_KEY0: key_w0 = i_cfg_data;
                    REG_KEY1: key_w1 = i_cfg_data;
                    default: ;
                endcase
            end
        end
        o_fail_cnt <= fail_cnt;
        o_pending <= expected_rsp_q.size();
        o_req_cnt <= req_cnt;
        o_text_cnt <= text_cnt;
        o_tag_cnt <= tag_cnt;
    end

endmodule

/* verif/ascon_aead_engine_tb.sv */
// ascon_aead_engine_tb: clock, reset, key writes and request/pop stimulus for the engine
// runs directed then random aead sessions under several idle/stall mixes and a long pop hold-off
// depends on asc_pkg, the engine rtl and ascon_aead_engine_checker

module ascon_aead_engine_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import asc_pkg::*;

    localparam int CLK_HALF = 5;
    localparam int RESET_CYCLES = 11;
    localparam int SETTLE_CYCLES = 48;
    localparam int HOLD_CYCLES = 300;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int MODE_REQS = 175;
    localparam int PRESSURE_TEXTS = 28;
    localparam logic [2:0] CMD_SPARE6 = 3'd6;
    localparam logic [2:0] CMD_SPARE7 = 3'd7;
    localparam logic [LANE_W-1:0] ALL_ONES = '1;
    localparam logic [LANE_W-1:0] TOP_BIT = 64'h8000000000000000;

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 push;
    logic                 full;
    t_in_item             i_req;
    logic                 empty;
    logic                 pop;
    t_out_item            o_rsp;
    logic                 i_cfg_we;
    logic [CFG_IDX_W-1:0] i_cfg_idx;
    logic [LANE_W-1:0]    i_cfg_data;

    int idle_pct;
    int stall_pct;
    bit hold_req;
    int req_sent = 0;
    int key_sets = 0;
    int quiet_cycles = 0;
    int fail_cnt;
    int pending_cnt;
    int req_cnt;
    int text_cnt;
    int tag_cnt;

    ascon_aead_engine i_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .push       (push),
        .full       (full),
        .i_req      (i_req),
        .empty      (empty),
        .pop        (pop),
        .o_rsp      (o_rsp),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data)
    );

    ascon_aead_engine_checker u_checker (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (push),
        .i_full     (full),
        .i_req      (i_req),
        .i_empty    (empty),
        .i_pop      (pop),
        .i_rsp      (o_rsp),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_fail_cnt (fail_cnt),
        .o_pending  (pending_cnt),
        .o_req_cnt  (req_cnt),
        .o_text_cnt (text_cnt),
        .o_tag_cnt  (tag_cnt)
    );

    initial i_clk = 1'b0;
    always #CLK_HALF i_clk = ~i_clk;

    always @(posedge i_clk) begin
        if ((push && !full) || (pop && !empty)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // response side: random stalls, plus one long hold-off when asked
    initial begin : rsp_side
        int held;
        bit served;
        pop = 1'b0;
        held = 0;
        served = 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_req && !served) begin
                pop <= 1'b0;
                held++;
                if (held >= HOLD_CYCLES) served = 1'b1;
            end else begin
                pop <= ($urandom_range(99) >= stall_pct);
                if (!hold_req) begin
                    served = 1'b0;
                    held = 0;
                end
            end
        end
    end

    function automatic logic [LANE_W-1:0] rnd64();
        return {$urandom, $urandom};
    endfunction

    function automatic t_in_item make_req(input logic [2:0] cmd, input logic [LANE_W-1:0] data,
                                          input logic [LANE_W-1:0] nonce, input logic last);
        t_in_item rq;
        rq.cmd = cmd;
        rq.data_in = data;
        rq.nonce_second = nonce;
        rq.is_last = last;
        return rq;
    endfunction

    task automatic send_req(input t_in_item rq);
        while ($urandom_range(99) < idle_pct) begin
            push <= 1'b0;
            @(posedge i_clk);
        end
        push <= 1'b1;
        i_req <= rq;
        @(posedge i_clk);
        while (full) @(posedge i_clk);
        if (rq.cmd <= CMD_FINALIZE) req_sent++;
    endtask

    task automatic set_key(input logic [LANE_W-1:0] k0, input logic [LANE_W-1:0] k1);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= REG_KEY0;
        i_cfg_data <= k0;
        @(posedge i_clk);
        i_cfg_idx <= REG_KEY1;
        i_cfg_data <= k1;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        key_sets++;
    endtask

    // trailing start/absorb requests give no response, so settle after the last one
    task automatic drain_block();
        push <= 1'b0;
        @(posedge i_clk);
        while (pending_cnt != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic run_directed();
        // text before any start works on the cleared lanes
        send_req(make_req(CMD_ENCRYPT, '0, '0, 1'b0));
        send_req(make_req(CMD_SPARE6, ALL_ONES, ALL_ONES, 1'b1));
        send_req(make_req(CMD_SPARE7, ALL_ONES, ALL_ONES, 1'b0));
        send_req(make_req(CMD_START, '0, '0, 1'b1));
        send_req(make_req(CMD_ABSORB, ALL_ONES, ALL_ONES, 1'b1));
        send_req(make_req(CMD_ABSORB, '0, '0, 1'b0));
        send_req(make_req(CMD_CLOSE_AD, ALL_ONES, ALL_ONES, 1'b1));
        send_req(make_req(CMD_ENCRYPT, ALL_ONES, '0, 1'b0));
        send_req(make_req(CMD_DECRYPT, '0, ALL_ONES, 1'b0));
        send_req(make_req(CMD_DECRYPT, ALL_ONES, '0, 1'b1));
        send_req(make_req(CMD_FINALIZE, '0, '0, 1'b0));
        send_req(make_req(CMD_FINALIZE, ALL_ONES, ALL_ONES, 1'b1));
        send_req(make_req(CMD_START, ALL_ONES, ALL_ONES, 1'b0));
        send_req(make_req(CMD_CLOSE_AD, '0, '0, 1'b0));
        send_req(make_req(CMD_CLOSE_AD, '0, '0, 1'b0));
        send_req(make_req(CMD_ENCRYPT, '0, '0, 1'b1));
        send_req(make_req(CMD_ENCRYPT, TOP_BIT, ALL_ONES, 1'b0));
        send_req(make_req(CMD_FINALIZE, '0, '0, 1'b1));
        send_req(make_req(CMD_ABSORB, TOP_BIT | 64'd1, '0, 1'b0));
        send_req(make_req(CMD_DECRYPT, 64'd1, TOP_BIT, 1'b0));
        send_req(make_req(CMD_FINALIZE, rnd64(), rnd64(), 1'b0));
    endtask

    // one aead session; a broken one loses a random step and marks text blocks last at random
    task automatic run_session(input bit broken);
        t_in_item seq[$];
        int       n_ad;
        int       n_txt;
        t_cmd     dir;
        logic     last;
        n_ad = $urandom_range(3);
        n_txt = $urandom_range(1, 4);
        dir = ($urandom_range(1) != 0) ? CMD_DECRYPT : CMD_ENCRYPT;
        seq.push_back(make_req(CMD_START, rnd64(), rnd64(), 1'($urandom_range(1))));
        repeat (n_ad) seq.push_back(make_req(CMD_ABSORB, rnd64(), rnd64(),
                                             1'($urandom_range(1))));
        seq.push_back(make_req(CMD_CLOSE_AD, rnd64(), rnd64(), 1'($urandom_range(1))));
        for (int k = 0; k < n_txt; k++) begin
            last = broken ? 1'($urandom_range(1)) : (k == n_txt - 1);
            seq.push_back(make_req(dir, rnd64(), rnd64(), last));
        end
        seq.push_back(make_req(CMD_FINALIZE, rnd64(), rnd64(), 1'($urandom_range(1))));
        if (broken) seq.delete($urandom_range(seq.size() - 1));
        foreach (seq[j]) send_req(seq[j]);
    endtask

    initial begin
        int m;
        int target;
        int roll;
        push = 1'b0;
        i_req = '0;
        i_cfg_we = 1'b0;
        i_cfg_idx = '0;
        i_cfg_data = '0;
        i_rst_n = 1'b0;
        hold_req = 1'b0;
        idle_pct = 0;
        stall_pct = 0;
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        set_key('0, '0);
        run_directed();
        drain_block();

        for (m = 0; m < 4; m++) begin
            case (m)
                0: begin
                    set_key(ALL_ONES, ALL_ONES);
                    idle_pct = 0;
                    stall_pct <= 0;
                end
                1: begin
                    set_key(rnd64(), rnd64());
                    idle_pct = 64;
                    stall_pct <= 0;
                end
                2: begin
                    set_key(ALL_ONES, '0);
                    idle_pct = 0;
                    stall_pct <= 64;
                end
                default: begin
                    set_key('0, ALL_ONES);
                    idle_pct = 23;
                    stall_pct <= 23;
                end
            endcase
            target = req_sent + MODE_REQS;
            while (req_sent < target) begin
                roll = $urandom_range(99);
                if (roll < 80) run_session(1'b0);
                else if (roll < 90) run_session(1'b1);
                else send_req(make_req(3'($urandom_range(7)), rnd64(), rnd64(),
                                       1'($urandom_range(1))));
            end
            drain_block();
        end

        // hold off pops so both queues fill and full backs up the request side
        set_key(rnd64(), rnd64());
        idle_pct = 0;
        stall_pct <= 0;
        hold_req <= 1'b1;
        send_req(make_req(CMD_START, rnd64(), rnd64(), 1'b0));
        repeat (PRESSURE_TEXTS) send_req(make_req(CMD_ENCRYPT, rnd64(), rnd64(), 1'b0));
        send_req(make_req(CMD_FINALIZE, rnd64(), rnd64(), 1'b0));
        drain_block();
        hold_req <= 1'b0;

        $display("covered %0d requests, %0d text and %0d tag responses checked",
                 req_cnt, text_cnt, tag_cnt);
        $display("four idle/stall mixes, one long pop hold-off, %0d key settings", key_sets);
        if (fail_cnt == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule

/* filelist.f */
rtl/asc_pkg.sv
rtl/asc_front.sv
rtl/asc_back.sv
rtl/asc_outq.sv
rtl/ascon_aead_engine.sv
verif/ascon_aead_engine_checker.sv
verif/ascon_aead_engine_tb.sv
